/* src/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg
// shared types and constants of the tone pattern sequencer
// ----------------------------------------------------------------------------
package tps_pkg;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_STOP  = 2'd3
    } req_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_TONE_VOLUME    = 2'd1,
        CFG_REPEAT_LIMIT   = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_idx_t;

    localparam int unsigned PATTERN_DEPTH_DEF = 256;
    localparam int unsigned POS_W             = 8;
    localparam int unsigned FREQ_W            = 16;
    localparam int unsigned DUR_W             = 32;
    localparam int unsigned TIME_W            = 32;
    localparam int unsigned DUTY_W            = 7;
    localparam int unsigned CFG_DATA_W        = 8;
    localparam int unsigned IN_DATA_W         = 88;
    localparam int unsigned OUT_DATA_W        = 32;

    localparam logic [DUTY_W-1:0] VOLUME_MAX   = 7'd100;
    localparam logic [DUTY_W-1:0] VOLUME_RESET = 7'd50;

endpackage

/* src/tone_pattern_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tone_pattern_sequencer_core
// plays a stored note pattern on a tone output, one result per request
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tuser: req_type; tdata: note fields, time
//  m_*     | out       | m_tvalid/m_tready  | tdata: tone_freq, tone_duty, flags
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  a request goes from acceptance to its result in the output register through
//  the pattern memory read register and then the note update; a new request is
//  taken every cycle while results drain. the next note address comes forward
//  from the update stage, so back-to-back ticks see the advanced position.
//  reset clears control state only; the pattern memory holds garbage until written.
//  a stalled output holds the update stage, which then holds the input side.
// ----------------------------------------------------------------------------
module tone_pattern_sequencer_core #(
    parameter int unsigned PATTERN_DEPTH = tps_pkg::PATTERN_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] note_slot, [23:8] note_freq, [55:24] note_length, [87:56] time_now
    input  logic [tps_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] req_type
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] tone_freq, [22:16] tone_duty, [23] playing, [24] tone_written, rest zero
    output logic [tps_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam logic [tps_pkg::POS_W:0] DEPTH_LIM = (tps_pkg::POS_W + 1)'(PATTERN_DEPTH);

    // configuration registers
    logic [tps_pkg::POS_W-1:0]  pattern_length_reg;
    logic [tps_pkg::DUTY_W-1:0] tone_volume_reg;
    logic [tps_pkg::POS_W-1:0]  repeat_limit_reg;
    logic [tps_pkg::DUTY_W-1:0] vol_sat;

    // pattern memories
    logic [tps_pkg::FREQ_W-1:0] freq_mem [PATTERN_DEPTH];
    logic [tps_pkg::DUR_W-1:0]  dur_mem  [PATTERN_DEPTH];
    logic [tps_pkg::FREQ_W-1:0] freq_rd_reg;
    logic [tps_pkg::DUR_W-1:0]  dur_rd_reg;

    // input fields
    tps_pkg::req_t              in_req;
    logic [tps_pkg::POS_W-1:0]  in_slot;
    logic [tps_pkg::FREQ_W-1:0] in_freq;
    logic [tps_pkg::DUR_W-1:0]  in_len;
    logic [tps_pkg::TIME_W-1:0] in_time;
    logic                       s_accept;

    // read address stage
    logic [tps_pkg::POS_W:0]    rd_incr;
    logic [tps_pkg::POS_W-1:0]  rd_next_pos;
    logic [tps_pkg::POS_W-1:0]  freq_addr;
    logic                       freq_ok;
    logic                       dur_ok;

    // update stage
    logic                       s1_valid_reg;
    tps_pkg::req_t              s1_req_reg;
    logic [tps_pkg::TIME_W-1:0] s1_time_reg;
    logic                       s1_freq_ok_reg;
    logic                       s1_dur_ok_reg;
    logic                       s1_adv;

    // sequencer state
    logic                       active_reg,  active_next;
    logic [tps_pkg::POS_W-1:0]  note_pos_reg, note_pos_next;
    logic [tps_pkg::POS_W-1:0]  passes_reg,  passes_next;
    logic [tps_pkg::TIME_W-1:0] began_reg,   began_next;
    logic [tps_pkg::FREQ_W-1:0] drv_freq_reg, drv_freq_next;
    logic [tps_pkg::DUTY_W-1:0] drv_duty_reg, drv_duty_next;
    logic                       written;

    logic [tps_pkg::FREQ_W-1:0] entry_freq;
    logic [tps_pkg::DUR_W-1:0]  entry_dur;
    logic [tps_pkg::TIME_W-1:0] elapsed;
    logic [tps_pkg::POS_W:0]    up_incr;
    logic [tps_pkg::POS_W-1:0]  passes_inc;

    // output register
    logic                          out_valid_reg;
    logic [tps_pkg::OUT_DATA_W-1:0] out_data_reg;

    assign in_req  = tps_pkg::req_t'(s_tuser);
    assign in_slot = s_tdata[7:0];
    assign in_freq = s_tdata[23:8];
    assign in_len  = s_tdata[55:24];
    assign in_time = s_tdata[87:56];

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign vol_sat   = (cfg_data[6:0] > tps_pkg::VOLUME_MAX) ? tps_pkg::VOLUME_MAX
                                                             : cfg_data[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            tone_volume_reg    <= tps_pkg::VOLUME_RESET;
            repeat_limit_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (tps_pkg::cfg_idx_t'(cfg_index))
                tps_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data;
                tps_pkg::CFG_TONE_VOLUME:    tone_volume_reg    <= vol_sat;
                tps_pkg::CFG_REPEAT_LIMIT:   repeat_limit_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // ---------------- read address ----------------
    // position comes from the update stage's next value so back-to-back ticks line up
    always_comb
    begin
        rd_incr     = {1'b0, note_pos_next} + 9'd1;
        rd_next_pos = (rd_incr >= {1'b0, pattern_length_reg}) ? '0 : rd_incr[7:0];
        freq_addr   = (in_req == tps_pkg::REQ_START) ? '0 : rd_next_pos;
        freq_ok     = ({1'b0, freq_addr} < DEPTH_LIM);
        dur_ok      = ({1'b0, note_pos_next} < DEPTH_LIM);
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            if (in_req == tps_pkg::REQ_WRITE && {1'b0, in_slot} < DEPTH_LIM)
            begin
                freq_mem[in_slot[ADDR_W-1:0]] <= in_freq;
                dur_mem[in_slot[ADDR_W-1:0]]  <= in_len;
            end
            freq_rd_reg <= freq_mem[freq_addr[ADDR_W-1:0]];
            dur_rd_reg  <= dur_mem[note_pos_next[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_req_reg     <= in_req;
            s1_time_reg    <= in_time;
            s1_freq_ok_reg <= freq_ok;
            s1_dur_ok_reg  <= dur_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // ---------------- note update ----------------
    assign entry_freq = s1_freq_ok_reg ? freq_rd_reg : '0;
    assign entry_dur  = s1_dur_ok_reg  ? dur_rd_reg  : '0;
    assign elapsed    = s1_time_reg - began_reg;
    assign up_incr    = {1'b0, note_pos_reg} + 9'd1;
    assign passes_inc = passes_reg + 8'd1;

    always_comb
    begin
        active_next   = active_reg;
        note_pos_next = note_pos_reg;
        passes_next   = passes_reg;
        began_next    = began_reg;
        drv_freq_next = drv_freq_reg;
        drv_duty_next = drv_duty_reg;
        written       = 1'b0;
        if (s1_adv)
        begin
            case (s1_req_reg)
                tps_pkg::REQ_WRITE: ;
                tps_pkg::REQ_START:
                begin
                    if (pattern_length_reg != '0)
                    begin
                        note_pos_next = '0;
                        passes_next   = '0;
                        active_next   = 1'b1;
                        began_next    = s1_time_reg;
                        written       = 1'b1;
                        if (entry_freq == '0 || tone_volume_reg == '0)
                        begin
                            drv_freq_next = '0;
                            drv_duty_next = '0;
                        end
                        else
                        begin
                            drv_freq_next = entry_freq;
                            drv_duty_next = tone_volume_reg;
                        end
                    end
                end
                tps_pkg::REQ_TICK:
                begin
                    if (active_reg && elapsed >= entry_dur)
                    begin
                        written = 1'b1;
                        if (up_incr >= {1'b0, pattern_length_reg})
                        begin
                            note_pos_next = '0;
                            passes_next   = passes_inc;
                        end
                        else
                        begin
                            note_pos_next = up_incr[7:0];
                        end
                        if (up_incr >= {1'b0, pattern_length_reg} &&
                            repeat_limit_reg != '0 && passes_inc >= repeat_limit_reg)
                        begin
                            // last pass done
                            active_next   = 1'b0;
                            drv_freq_next = '0;
                            drv_duty_next = '0;
                        end
                        else
                        begin
                            began_next = s1_time_reg;
                            if (entry_freq == '0 || tone_volume_reg == '0)
                            begin
                                drv_freq_next = '0;
                                drv_duty_next = '0;
                            end
                            else
                            begin
                                drv_freq_next = entry_freq;
                                drv_duty_next = tone_volume_reg;
                            end
                        end
                    end
                end
                tps_pkg::REQ_STOP:
                begin
                    active_next   = 1'b0;
                    drv_freq_next = '0;
                    drv_duty_next = '0;
                    written       = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            note_pos_reg <= '0;
            passes_reg   <= '0;
            began_reg    <= '0;
            drv_freq_reg <= '0;
            drv_duty_reg <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            note_pos_reg <= note_pos_next;
            passes_reg   <= passes_next;
            began_reg    <= began_next;
            drv_freq_reg <= drv_freq_next;
            drv_duty_reg <= drv_duty_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_data_reg <= {7'd0, written, active_next, drv_duty_next, drv_freq_next};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (drv_freq_reg == '0 && drv_duty_reg == '0))
        else $error("idle sequencer drives a tone");

    a_silence_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (drv_freq_reg == '0) == (drv_duty_reg == '0))
        else $error("frequency and duty disagree on silence");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        drv_duty_reg <= tps_pkg::VOLUME_MAX && tone_volume_reg <= tps_pkg::VOLUME_MAX)
        else $error("duty above maximum");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> s1_valid_reg)
        else $error("accepted transaction lost before update stage");

    a_pos_fixed_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |-> note_pos_next == note_pos_reg)
        else $error("note position moved without an update");

endmodule

/* tb/sv/tone_pattern_sequencer_core_tb.sv */
// ----------------------------------------------------------------------------
// tone_pattern_sequencer_core_tb
// self-checking bench: streams note writes, starts, ticks and stops into the
// sequencer, predicts every tone result in step and checks it field by field,
// with random bursts on the input and random stalls on the output
// ----------------------------------------------------------------------------
module tone_pattern_sequencer_core_tb;

    localparam int RANDOM_ITEMS = 1360;

    typedef struct packed {
        tps_pkg::req_t                 kind;
        logic [tps_pkg::IN_DATA_W-1:0] data;
    } request_t;

    typedef struct packed {
        logic [tps_pkg::FREQ_W-1:0] freq;
        logic [tps_pkg::DUTY_W-1:0] duty;
        logic                       playing;
        logic                       written;
    } tone_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [tps_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]                     s_tuser   = tps_pkg::REQ_WRITE;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [tps_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index = tps_pkg::CFG_PATTERN_LENGTH;
    logic [tps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    tone_pattern_sequencer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [tps_pkg::FREQ_W-1:0] freq_mem [256];
    logic [tps_pkg::DUR_W-1:0]  dur_mem  [256];
    logic                       is_playing = 1'b0;
    logic [tps_pkg::POS_W-1:0]  pos        = '0;
    logic [7:0]                 passes     = '0;
    logic [tps_pkg::TIME_W-1:0] began      = '0;
    logic [tps_pkg::FREQ_W-1:0] drv_freq   = '0;
    logic [tps_pkg::DUTY_W-1:0] drv_duty   = '0;
    logic [7:0]                 pat_len    = '0;
    logic [tps_pkg::DUTY_W-1:0] volume     = tps_pkg::VOLUME_RESET;
    logic [7:0]                 rep_limit  = '0;

    request_t request_queue [$];
    tone_t    pending_tones [$];
    request_t cur_req;
    logic     req_pending = 1'b0;
    logic [tps_pkg::TIME_W-1:0] tick_clock = '0;

    int errors = 0;
    int queued = 0;
    int results_checked = 0;
    int tone_updates = 0;
    int completions = 0;
    int cfg_writes = 0;
    int kind_count [4] = '{0, 0, 0, 0};

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic void set_tone(logic [tps_pkg::FREQ_W-1:0] f);
        if (f == '0 || volume == '0) begin
            drv_freq = '0;
            drv_duty = '0;
        end
        else begin
            drv_freq = f;
            drv_duty = volume;
        end
    endfunction

    function automatic tone_t play_request(request_t rq);
        logic [7:0]                 slot;
        logic [tps_pkg::FREQ_W-1:0] nfreq;
        logic [tps_pkg::DUR_W-1:0]  nlen;
        logic [tps_pkg::TIME_W-1:0] now;
        logic [tps_pkg::TIME_W-1:0] elapsed;
        logic [8:0]                 next;
        logic                       done;
        tone_t                      r;
        slot  = rq.data[7:0];
        nfreq = rq.data[23:8];
        nlen  = rq.data[55:24];
        now   = rq.data[87:56];
        done  = 1'b0;
        r.written = 1'b0;
        kind_count[int'(rq.kind)]++;
        case (rq.kind)
            tps_pkg::REQ_WRITE: begin
                freq_mem[slot] = nfreq;
                dur_mem[slot]  = nlen;
            end
            tps_pkg::REQ_START: begin
                if (pat_len != 0) begin
                    pos        = '0;
                    passes     = '0;
                    is_playing = 1'b1;
                    began      = now;
                    set_tone(freq_mem[0]);
                    r.written  = 1'b1;
                end
            end
            tps_pkg::REQ_TICK: begin
                if (is_playing) begin
                    elapsed = now - began;
                    if (elapsed >= dur_mem[pos]) begin
                        next = {1'b0, pos} + 9'd1;
                        if (next >= {1'b0, pat_len}) begin
                            next   = '0;
                            passes = passes + 8'd1;
                            if (rep_limit != 0 && passes >= rep_limit)
                                done = 1'b1;
                        end
                        pos = next[7:0];
                        if (done) begin
                            is_playing = 1'b0;
                            drv_freq   = '0;
                            drv_duty   = '0;
                            completions++;
                        end
                        else begin
                            set_tone(freq_mem[pos]);
                            began = now;
                        end
                        r.written = 1'b1;
                    end
                end
            end
            default: begin
                is_playing = 1'b0;
                drv_freq   = '0;
                drv_duty   = '0;
                r.written  = 1'b1;
            end
        endcase
        r.freq    = drv_freq;
        r.duty    = drv_duty;
        r.playing = is_playing;
        if (r.written)
            tone_updates++;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_request(tps_pkg::req_t kind, logic [7:0] slot,
                                          logic [15:0] freq, logic [31:0] len,
                                          logic [31:0] now);
        request_t rq;
        rq.kind = kind;
        rq.data = {now, len, freq, slot};
        request_queue.push_back(rq);
        queued++;
    endfunction

    // control requests carry random junk in the note fields
    function automatic void queue_control(tps_pkg::req_t kind, logic [31:0] now);
        queue_request(kind, 8'($urandom()), 16'($urandom()), $urandom(), now);
    endfunction

    function automatic logic [15:0] rand_freq();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 16'h0000;
        else if (r < 5)
            return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // mostly short notes so ticks keep the pattern moving
    function automatic logic [31:0] rand_duration();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 32'd0;
        else if (r == 3)
            return 32'hFFFF_FFFF;
        else if (r == 4)
            return $urandom();
        return 32'($urandom_range(1, 10));
    endfunction

    task automatic cfg_write(tps_pkg::cfg_idx_t idx, logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tps_pkg::CFG_PATTERN_LENGTH: pat_len = value;
            tps_pkg::CFG_TONE_VOLUME:
                volume = (value[6:0] > tps_pkg::VOLUME_MAX) ? tps_pkg::VOLUME_MAX
                                                            : value[6:0];
            tps_pkg::CFG_REPEAT_LIMIT:   rep_limit = value;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // every request yields a result, so an empty result queue means idle
    task automatic wait_drained();
        @(negedge clk);
        while (request_queue.size() != 0 || req_pending || pending_tones.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of random length, random gaps, occasional steady stretches
    // ------------------------------------------------------------------------
    int  burst_left = 1;
    int  gap_left   = 0;
    logic steady    = 1'b0;

    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else if (!req_pending) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (request_queue.size() != 0) begin
                cur_req = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_req.kind;
                s_tdata  <= cur_req.data;
                req_pending = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end
                else begin
                    if ($urandom_range(0, 9) == 0)
                        steady = ~steady;
                    burst_left = $urandom_range(1, 24);
                    gap_left   = steady ? 0 : $urandom_range(0, 7);
                end
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: ready runs and stall runs, now and then a long ready stretch
    // ------------------------------------------------------------------------
    int ready_run = 0;
    int stall_run = 0;

    always @(negedge clk) begin
        if (ready_run != 0) begin
            ready_run--;
            m_tready <= 1'b1;
        end
        else if (stall_run != 0) begin
            stall_run--;
            m_tready <= 1'b0;
        end
        else begin
            ready_run = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
            stall_run = $urandom_range(0, 5);
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // input acceptance and result checking
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        tone_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                pending_tones.push_back(play_request(cur_req));
                req_pending = 1'b0;
            end
            if (m_tvalid && m_tready) begin
                if (pending_tones.size() == 0) begin
                    $error("result transaction with no request waiting: m_tdata=%h", m_tdata);
                    errors++;
                end
                else begin
                    want = pending_tones.pop_front();
                    results_checked++;
                    if (m_tdata[15:0] !== want.freq) begin
                        $error("tone_freq: expected %0d, got %0d", want.freq, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[22:16] !== want.duty) begin
                        $error("tone_duty: expected %0d, got %0d", want.duty, m_tdata[22:16]);
                        errors++;
                    end
                    if (m_tdata[23] !== want.playing) begin
                        $error("playing: expected %0d, got %0d", want.playing, m_tdata[23]);
                        errors++;
                    end
                    if (m_tdata[24] !== want.written) begin
                        $error("tone_written: expected %0d, got %0d", want.written, m_tdata[24]);
                        errors++;
                    end
                    if (m_tdata[31:25] !== '0) begin
                        $error("padding: expected 0, got %h", m_tdata[31:25]);
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int random_start;
        int n;
        int r;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // preload every slot so no note is ever read before it is written
        for (int i = 0; i < 256; i++)
            queue_request(tps_pkg::REQ_WRITE, 8'(i), rand_freq(),
                          (i < 8) ? 32'd0 : rand_duration(), $urandom());
        wait_drained();

        // extremes, wraparound of elapsed time, rest note, end of limited run
        cfg_write(tps_pkg::CFG_PATTERN_LENGTH, 8'd3);
        cfg_write(tps_pkg::CFG_TONE_VOLUME, 8'hFF);
        cfg_write(tps_pkg::CFG_REPEAT_LIMIT, 8'd1);
        queue_request(tps_pkg::REQ_WRITE, 8'd0, 16'hFFFF, 32'd2, 32'd0);
        queue_request(tps_pkg::REQ_WRITE, 8'd1, 16'h0000, 32'd0, 32'hFFFF_FFFF);
        queue_request(tps_pkg::REQ_WRITE, 8'd2, 16'h0001, 32'hFFFF_FFFF, 32'd0);
        queue_request(tps_pkg::REQ_WRITE, 8'd255, 16'h1234, 32'd5, 32'd0);
        queue_control(tps_pkg::REQ_TICK, 32'd7);
        queue_control(tps_pkg::REQ_START, 32'hFFFF_FFFE);
        queue_control(tps_pkg::REQ_TICK, 32'hFFFF_FFFF);
        queue_control(tps_pkg::REQ_TICK, 32'd0);
        queue_control(tps_pkg::REQ_TICK, 32'd0);
        queue_control(tps_pkg::REQ_TICK, 32'd5);
        queue_control(tps_pkg::REQ_TICK, 32'hFFFF_FFFF);
        queue_control(tps_pkg::REQ_TICK, 32'd3);
        queue_control(tps_pkg::REQ_STOP, 32'd3);
        queue_control(tps_pkg::REQ_START, 32'd100);
        queue_control(tps_pkg::REQ_STOP, 32'd101);
        wait_drained();

        // endless repeat, then shrink the pattern under the playing position
        cfg_write(tps_pkg::CFG_PATTERN_LENGTH, 8'd8);
        cfg_write(tps_pkg::CFG_TONE_VOLUME, 8'd100);
        cfg_write(tps_pkg::CFG_REPEAT_LIMIT, 8'd0);
        queue_control(tps_pkg::REQ_START, 32'd10);
        queue_control(tps_pkg::REQ_TICK, 32'd12);
        queue_control(tps_pkg::REQ_TICK, 32'd12);
        queue_control(tps_pkg::REQ_TICK, 32'd11);
        queue_control(tps_pkg::REQ_TICK, 32'd11);
        queue_control(tps_pkg::REQ_TICK, 32'd11);
        wait_drained();
        cfg_write(tps_pkg::CFG_PATTERN_LENGTH, 8'd2);
        cfg_write(tps_pkg::CFG_TONE_VOLUME, 8'h80);
        cfg_write(tps_pkg::CFG_REPEAT_LIMIT, 8'd3);
        queue_control(tps_pkg::REQ_TICK, 32'd11);
        queue_control(tps_pkg::REQ_STOP, 32'd11);
        wait_drained();

        // empty pattern: start has no effect
        cfg_write(tps_pkg::CFG_PATTERN_LENGTH, 8'd0);
        cfg_write(tps_pkg::CFG_UNUSED, 8'hFF);
        queue_control(tps_pkg::REQ_START, 32'd20);
        queue_control(tps_pkg::REQ_TICK, 32'd30);
        wait_drained();

        random_start = queued;
        while (queued - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    cfg_write(tps_pkg::CFG_PATTERN_LENGTH, 8'd0);
                else if (r == 1)
                    cfg_write(tps_pkg::CFG_PATTERN_LENGTH, 8'd255);
                else if (r == 2)
                    cfg_write(tps_pkg::CFG_PATTERN_LENGTH, 8'($urandom()));
                else
                    cfg_write(tps_pkg::CFG_PATTERN_LENGTH, 8'($urandom_range(1, 8)));
            end
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    cfg_write(tps_pkg::CFG_TONE_VOLUME, 8'd0);
                else if (r == 1)
                    cfg_write(tps_pkg::CFG_TONE_VOLUME, 8'd100);
                else if (r == 2)
                    cfg_write(tps_pkg::CFG_TONE_VOLUME, 8'($urandom_range(101, 127)));
                else
                    cfg_write(tps_pkg::CFG_TONE_VOLUME, 8'($urandom()));
            end
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 9);
                if (r < 3)
                    cfg_write(tps_pkg::CFG_REPEAT_LIMIT, 8'd0);
                else if (r == 9)
                    cfg_write(tps_pkg::CFG_REPEAT_LIMIT, 8'd255);
                else if (r == 8)
                    cfg_write(tps_pkg::CFG_REPEAT_LIMIT, 8'($urandom()));
                else
                    cfg_write(tps_pkg::CFG_REPEAT_LIMIT, 8'($urandom_range(1, 3)));
            end

            if ($urandom_range(0, 99) < 80) begin
                // well-formed run: a few note writes, start, a stream of ticks
                n = $urandom_range(0, 4);
                for (int k = 0; k < n; k++)
                    queue_request(tps_pkg::REQ_WRITE,
                                  (pat_len != 0) ? 8'($urandom_range(0, pat_len - 1))
                                                 : 8'($urandom()),
                                  rand_freq(), rand_duration(), $urandom());
                r = $urandom_range(0, 9);
                if (r == 0)
                    tick_clock = 32'hFFFF_FFFF - $urandom_range(0, 40);
                else if (r == 1)
                    tick_clock = $urandom();
                else
                    tick_clock = tick_clock + $urandom_range(0, 50);
                queue_control(tps_pkg::REQ_START, tick_clock);
                n = $urandom_range(8, 60);
                for (int k = 0; k < n; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        tick_clock = $urandom();
                    else if (r < 7)
                        tick_clock = tick_clock - $urandom_range(1, 3);
                    else
                        tick_clock = tick_clock + $urandom_range(0, 6);
                    if (r == 50)
                        queue_control(tps_pkg::REQ_START, tick_clock);
                    else if (r == 51)
                        queue_request(tps_pkg::REQ_WRITE, 8'($urandom()), rand_freq(),
                                      rand_duration(), $urandom());
                    else
                        queue_control(tps_pkg::REQ_TICK, tick_clock);
                end
                if ($urandom_range(0, 1) == 0)
                    queue_control(tps_pkg::REQ_STOP, tick_clock);
            end
            else begin
                // noise: any kind, any field values
                n = $urandom_range(10, 30);
                for (int k = 0; k < n; k++)
                    queue_request(tps_pkg::req_t'($urandom_range(0, 3)), 8'($urandom()),
                                  16'($urandom()), rand_duration(), $urandom());
            end
            wait_drained();
        end

        // let any stray result show up
        repeat (20) @(negedge clk);
        $display("covered %0d requests: %0d note writes, %0d starts, %0d ticks, %0d stops",
                 queued, kind_count[tps_pkg::REQ_WRITE], kind_count[tps_pkg::REQ_START],
                 kind_count[tps_pkg::REQ_TICK], kind_count[tps_pkg::REQ_STOP]);
        $display("%0d register writes, %0d results checked, %0d tone updates, %0d finished runs",
                 cfg_writes, results_checked, tone_updates, completions);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results still outstanding", pending_tones.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
